FILE: design/lfsa_pkg.sv
// ----------------------------------------------------------------------------
// lfsa_pkg
// shared types, constants and helpers for the lowest free slot allocator
// ----------------------------------------------------------------------------
package lfsa_pkg;

    localparam int SLOTS_DEF  = 1024;
    localparam int SLOT_W     = 10;
    localparam int HW_W       = 11;
    localparam int WORD_W     = 32;
    localparam int BIT_W      = 5;
    localparam logic [HW_W-1:0] POOL_RESET = 11'd1024;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_FULL = 2'd1;
    localparam status_t ST_BAD  = 2'd2;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WRITE
    } state_t;

    // index of the lowest set bit, 31 when none is set
    function automatic logic [BIT_W-1:0] lowest_bit32(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = 5'd31;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: design/lfsa_ram.sv
// ----------------------------------------------------------------------------
// lfsa_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module lfsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/lowest_free_slot_allocator.sv
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator
// single pool slot allocator: lowest released slot first, else high-water mark
// ----------------------------------------------------------------------------
// order: accept, bitmap read in S_READ, then modify/write in S_WRITE, held until the
//   result register is free; a new request is taken only after the last one commits,
//   since the free bitmap ram is read-modify-written through its registered read
// reset: synchronous, active low; the per-word valid flops clear at once so the
//   bitmap reads as all free-less zeros, no clearing pass; mark 0, pool 1024
module lowest_free_slot_allocator
    import lfsa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration: pool size
    input  logic              cfg_wr_en,
    input  logic [HW_W-1:0]   cfg_wr_data,
    // request channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [SLOT_W-1:0] s_slot,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SLOT_W-1:0] m_granted_slot,
    output logic [1:0]        m_status
);

    // bitmap geometry follows the pool depth
    localparam int WORDS = (SLOTS + WORD_W - 1) / WORD_W;
    localparam int WIDX  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [HW_W-1:0] SLOTS_LIM = HW_W'(SLOTS);

    // control state
    state_t            state_reg, state_next;
    logic [WORDS-1:0]  summary_reg, summary_next;
    logic [WORDS-1:0]  wvalid_reg, wvalid_next;
    logic [HW_W-1:0]   high_water_reg, high_water_next;
    logic [HW_W-1:0]   pool_size_reg;
    logic              m_valid_reg;

    // captured request and lookup
    logic              cmd_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [WIDX-1:0]   widx_reg;
    logic              hit_reg;

    // result register
    logic [SLOT_W-1:0] m_granted_reg;
    status_t           m_status_reg;

    // ram side
    logic              ram_re;
    logic              ram_we;
    logic [WIDX-1:0]   ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] new_word;

    // modify stage results
    logic [SLOT_W-1:0] granted;
    status_t           status;
    logic              commit;
    logic              out_free;
    logic              accept;

    logic [WORD_W-1:0] word;
    logic [BIT_W-1:0]  low_bit;
    logic [BIT_W-1:0]  sum_low;
    logic [HW_W-1:0]   limit;
    logic              range_bad;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == S_WRITE) && out_free;

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_READ;
            S_READ:  state_next = S_WRITE;
            // hold the modify step until the result register can take the word
            S_WRITE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        s_ready = 1'b0;
        ram_re  = 1'b0;
        case (state_reg)
            S_IDLE:  s_ready = 1'b1;
            S_READ:  ram_re  = 1'b1;
            S_WRITE: ;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // read address: lowest summary word on allocate, the slot's word on release
    // ------------------------------------------------------------------
    assign sum_low = lowest_bit32(WORD_W'(summary_reg));

    always_comb begin
        if (cmd_reg == CMD_ALLOC) begin
            ram_raddr = WIDX'(sum_low);
        end else begin
            ram_raddr = WIDX'(slot_reg[SLOT_W-1:BIT_W]);
        end
    end

    lfsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS),
        .AW    (WIDX)
    ) u_free_map (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (widx_reg),
        .wdata (new_word),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // modify step
    // ------------------------------------------------------------------
    // never-written words read as no slot released
    assign word    = wvalid_reg[widx_reg] ? ram_rdata : '0;
    assign low_bit = lowest_bit32(word);
    assign limit   = (pool_size_reg < SLOTS_LIM) ? pool_size_reg : SLOTS_LIM;
    assign range_bad = ({1'b0, slot_reg} >= high_water_reg) || ({1'b0, slot_reg} >= SLOTS_LIM);

    always_comb begin
        new_word        = word;
        ram_we          = 1'b0;
        granted         = '0;
        status          = ST_OK;
        high_water_next = high_water_reg;
        summary_next    = summary_reg;
        wvalid_next     = wvalid_reg;

        if (cmd_reg == CMD_ALLOC) begin
            if (hit_reg) begin
                // reuse the lowest released slot
                new_word = word & ~(WORD_W'(1) << low_bit);
                ram_we   = 1'b1;
                granted  = SLOT_W'({widx_reg, low_bit});
            end else if (high_water_reg < limit) begin
                // hand out from the top
                granted         = high_water_reg[SLOT_W-1:0];
                high_water_next = high_water_reg + 1'b1;
            end else begin
                status = ST_FULL;
            end
        end else begin
            if (range_bad || word[slot_reg[BIT_W-1:0]]) begin
                status = ST_BAD;
            end else if ((HW_W'(slot_reg) + 1'b1) == high_water_reg) begin
                // top slot back: just lower the mark
                high_water_next = high_water_reg - 1'b1;
            end else begin
                new_word = word | (WORD_W'(1) << slot_reg[BIT_W-1:0]);
                ram_we   = 1'b1;
            end
        end

        if (ram_we) begin
            summary_next[widx_reg] = |new_word;
            wvalid_next[widx_reg]  = 1'b1;
        end

        // only the committing cycle changes anything
        if (!commit) begin
            ram_we          = 1'b0;
            high_water_next = high_water_reg;
            summary_next    = summary_reg;
            wvalid_next     = wvalid_reg;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            summary_reg    <= '0;
            wvalid_reg     <= '0;
            high_water_reg <= '0;
            pool_size_reg  <= POOL_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            summary_reg    <= summary_next;
            wvalid_reg     <= wvalid_next;
            high_water_reg <= high_water_next;
            if (cfg_wr_en) begin
                pool_size_reg <= cfg_wr_data;
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= s_cmd;
            slot_reg <= s_slot;
        end
        if (state_reg == S_READ) begin
            widx_reg <= ram_raddr;
            hit_reg  <= |summary_reg;
        end
        if (commit) begin
            m_granted_reg <= granted;
            m_status_reg  <= status;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_granted_slot = m_granted_reg;
    assign m_status       = m_status_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_we_in_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_WRITE) && out_free)
        else $error("bitmap write outside the modify step");

    a_mark_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        high_water_reg <= SLOTS_LIM)
        else $error("high-water mark beyond pool depth");

    a_zero_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> (m_granted_slot == '0))
        else $error("nonzero slot on a failed request");

    a_accept_read: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_READ) && ram_re)
        else $error("accepted word not followed by a bitmap read");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_WRITE))
        else $error("result raised outside the modify step");

endmodule
